// ----- sv/sbm_pkg.sv -----
// Shared types and constants of the separable box mean filter.
package sbm_pkg;

    // Configuration port widths and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

    // Register field widths and reset values
    localparam int FW_BITS = 10;
    localparam int FH_BITS = 16;
    localparam int FR_BITS = 4;
    localparam logic [FW_BITS-1:0] FW_RESET = 10'd64;
    localparam logic [FH_BITS-1:0] FH_RESET = 16'd64;
    localparam logic [FR_BITS-1:0] FR_RESET = 4'd2;

    // Port field widths
    localparam int PIX_IN_W = 16;
    localparam int MEAN_W   = 16;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept_px;
        logic hsum_start;
        logic hsum_step;
        logic vsum_start;
        logic vsum_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic row_done;
        logic emit_ok;
        logic hsum_ok;
        logic tap_last;
        logic center_last;
        logic vsum_done;
        logic div_last;
    } t_sts;

endpackage

// ----- sv/separable_box_mean_filter.sv -----
// Separable box mean filter: top level joining controller and datapath.
// Raster pixels enter one item at a time; each result is the window mean of
// side 2r+1, rounded to nearest, delayed by r*width+r pixel items, and drain
// items (func=1) after the last pixel flush the remaining results. A pixel
// item stores no horizontal sum for the first r pixels of a row, one sum
// otherwise and r+1 sums on a row's last pixel. The single horizontal adder
// takes one tap per cycle, the line memory gives one row sum per cycle, and
// the divider gives one quotient bit per cycle. A finished result waits in
// the output register while the next item is accepted. A configuration
// write to the width, height or radius register restarts the frame; the
// configuration port is always ready.
module separable_box_mean_filter #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 512,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_func,
    input  logic [sbm_pkg::PIX_IN_W-1:0]     i_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sbm_pkg::MEAN_W-1:0]       o_mean_value,
    output logic                             o_frame_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    sbm_pkg::t_cmd cmd;
    sbm_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    sbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sbm_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pixel      (i_pixel),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_mean_value (o_mean_value),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ----- sv/sbm_datapath.sv -----
// Datapath: config registers, positions, line stores, sums and divider.
module sbm_datapath #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 512,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [sbm_pkg::PIX_IN_W-1:0]     i_pixel,
    input  sbm_pkg::t_cmd                    i_cmd,
    output sbm_pkg::t_sts                    o_sts,
    output logic [sbm_pkg::MEAN_W-1:0]       o_mean_value,
    output logic                             o_frame_end
);

    localparam int SPAN  = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(SPAN);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int HIW   = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
    localparam int HW    = PIXEL_BITS + $clog2(SPAN);
    localparam int VW    = PIXEL_BITS + $clog2(SPAN * SPAN);
    localparam int NW    = VW + 1;
    localparam int S2W   = $clog2(SPAN * SPAN + 1);
    localparam int DW    = S2W + PIXEL_BITS;
    localparam int CMPW  = (NW > DW) ? NW : DW;
    localparam int DEPTH = SPAN * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SQW   = CW + 2;
    localparam int JW    = $clog2(SPAN + 1);
    localparam int IW    = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
    localparam int FH    = sbm_pkg::FH_BITS;

    // Configuration registers
    logic [sbm_pkg::FW_BITS-1:0] r_cfg_w;
    logic [FH-1:0]               r_cfg_h;
    logic [sbm_pkg::FR_BITS-1:0] r_cfg_r;
    logic                        cfg_restart;

    // Positions
    logic [CW-1:0] r_col, r_ox;
    logic [SW-1:0] r_ws, r_rs, r_oys;
    logic [FH-1:0] r_row, r_oy;

    // Latched item
    logic [CW-1:0] r_col_in;
    logic [SW-1:0] r_ws_in, r_rs_in;

    // Row stores
    logic [PIXEL_BITS-1:0] r_win  [SPAN];
    logic [PIXEL_BITS-1:0] r_head [MAX_RADIUS];
    logic [HW-1:0]         r_mem  [DEPTH];
    logic [HW-1:0]         r_rdata;

    // Horizontal sum
    logic [CW-1:0] r_c, r_cend;
    logic [SW-1:0] r_k;
    logic [HW-1:0] r_hacc;

    // Vertical sum
    logic [JW-1:0] r_j;
    logic          r_pend;
    logic [VW-1:0] r_vacc;

    // Divider
    logic [NW-1:0]         r_rem;
    logic [DW-1:0]         r_dsh;
    logic [IW-1:0]         r_i;
    logic [PIXEL_BITS-1:0] r_quot;

    logic [sbm_pkg::MEAN_W-1:0] r_mean;
    logic                       r_fend;

    // Effective (clamped) settings
    logic [WW-1:0]  eff_w, w_m1;
    logic [FH-1:0]  eff_h;
    logic [RW-1:0]  eff_r;
    logic [RW:0]    two_r;
    logic [S2W-1:0] side_x, s2;

    always_comb begin
        if (16'(r_cfg_w) < 16'(SPAN)) begin
            eff_w = WW'(SPAN);
        end else if (16'(r_cfg_w) > 16'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h < FH'(SPAN)) begin
            eff_h = FH'(SPAN);
        end else begin
            eff_h = r_cfg_h;
        end
        if (r_cfg_r == '0) begin
            eff_r = RW'(1);
        end else if (8'(r_cfg_r) > 8'(MAX_RADIUS)) begin
            eff_r = RW'(MAX_RADIUS);
        end else begin
            eff_r = RW'(r_cfg_r);
        end
        w_m1   = eff_w - WW'(1);
        two_r  = {eff_r, 1'b0};
        side_x = S2W'(two_r) + S2W'(1);
        s2     = side_x * side_x;
    end

    // Input position status
    logic col_last, col_ge_r;
    assign col_last = (WW'(r_col) == w_m1);
    assign col_ge_r = (16'(r_col) >= 16'(eff_r));

    // Horizontal tap selection
    logic signed [SQW-1:0] q_s, m_s, d_s, hid_s;
    logic                  q_neg, q_hi;
    logic [SW-1:0]         d;
    logic [SW:0]           wsl_raw;
    logic [SW-1:0]         wslot;
    logic [PIXEL_BITS-1:0] tap;
    logic [HW-1:0]         hsum_next;
    logic [AW-1:0]         wr_addr;
    logic                  tap_last;

    always_comb begin
        q_s     = signed'(SQW'(r_c)) - signed'(SQW'(eff_r)) + signed'(SQW'(r_k));
        q_neg   = q_s[SQW-1];
        q_hi    = !q_neg && (q_s >= signed'(SQW'(eff_w)));
        m_s     = q_hi ? (q_s - signed'(SQW'(eff_r))) : q_s;
        d_s     = signed'(SQW'(r_col_in)) - m_s;
        d       = SW'(d_s);
        wsl_raw = (SW+1)'(r_ws_in) + (SW+1)'(SPAN) - (SW+1)'(d);
        if (wsl_raw >= (SW+1)'(SPAN)) begin
            wslot = SW'(wsl_raw - (SW+1)'(SPAN));
        end else begin
            wslot = SW'(wsl_raw);
        end
        hid_s     = q_s + signed'(SQW'(eff_r));
        tap       = q_neg ? r_head[HIW'(hid_s)] : r_win[wslot];
        hsum_next = r_hacc + HW'(tap);
        wr_addr   = AW'(r_rs_in) * AW'(MAX_WIDTH) + AW'(r_c);
        tap_last  = ((SW+1)'(r_k) == (SW+1)'(two_r));
    end

    // Vertical row selection
    logic          issue, top, bot;
    logic [FH:0]   oj;
    logic [SW+1:0] vsl_raw, vsub;
    logic [SW-1:0] vslot;
    logic [AW-1:0] rd_addr;

    always_comb begin
        issue = ((SW+1)'(r_j) <= (SW+1)'(two_r));
        oj    = (FH+1)'(r_oy) + (FH+1)'(r_j);
        top   = oj < (FH+1)'(eff_r);
        bot   = oj >= ((FH+1)'(eff_h) + (FH+1)'(eff_r));
        priority if (top) begin
            vsub = '0;
        end else if (bot) begin
            vsub = (SW+2)'(two_r);
        end else begin
            vsub = (SW+2)'(eff_r);
        end
        vsl_raw = (SW+2)'(r_oys) + (SW+2)'(SPAN) + (SW+2)'(r_j) - vsub;
        priority if (vsl_raw >= (SW+2)'(2 * SPAN)) begin
            vslot = SW'(vsl_raw - (SW+2)'(2 * SPAN));
        end else if (vsl_raw >= (SW+2)'(SPAN)) begin
            vslot = SW'(vsl_raw - (SW+2)'(SPAN));
        end else begin
            vslot = SW'(vsl_raw);
        end
        rd_addr = AW'(vslot) * AW'(MAX_WIDTH) + AW'(r_ox);
    end

    // Divider compare and output position
    logic div_ge, fend;
    assign div_ge = (CMPW'(r_rem) >= CMPW'(r_dsh));
    assign fend   = (r_oy == eff_h - FH'(1)) && (WW'(r_ox) == w_m1);

    // Configuration writes
    always_comb begin
        cfg_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbm_pkg::CFG_FRAME_WIDTH:   cfg_restart = 1'b1;
                sbm_pkg::CFG_FRAME_HEIGHT:  cfg_restart = 1'b1;
                sbm_pkg::CFG_WINDOW_RADIUS: cfg_restart = 1'b1;
                default:                    cfg_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= sbm_pkg::FW_RESET;
            r_cfg_h <= sbm_pkg::FH_RESET;
            r_cfg_r <= sbm_pkg::FR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sbm_pkg::CFG_FRAME_WIDTH) begin
                r_cfg_w <= sbm_pkg::FW_BITS'(i_cfg_data);
            end
            if (i_cfg_index == sbm_pkg::CFG_FRAME_HEIGHT) begin
                r_cfg_h <= FH'(i_cfg_data);
            end
            if (i_cfg_index == sbm_pkg::CFG_WINDOW_RADIUS) begin
                r_cfg_r <= sbm_pkg::FR_BITS'(i_cfg_data);
            end
        end
    end

    // Input and output positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart || (i_cmd.out_load && fend)) begin
            r_col <= '0;
            r_ws  <= '0;
            r_row <= '0;
            r_rs  <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
            r_oys <= '0;
        end else begin
            if (i_cmd.accept_px) begin
                if (col_last) begin
                    r_col <= '0;
                    r_ws  <= '0;
                    r_row <= r_row + FH'(1);
                    r_rs  <= (r_rs == SW'(SPAN - 1)) ? '0 : r_rs + SW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                    r_ws  <= (r_ws == SW'(SPAN - 1)) ? '0 : r_ws + SW'(1);
                end
            end
            if (i_cmd.out_load) begin
                if (WW'(r_ox) == w_m1) begin
                    r_ox  <= '0;
                    r_oy  <= r_oy + FH'(1);
                    r_oys <= (r_oys == SW'(SPAN - 1)) ? '0 : r_oys + SW'(1);
                end else begin
                    r_ox <= r_ox + CW'(1);
                end
            end
        end
    end

    // Store pixel and latch its position
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_px) begin
            r_win[r_ws] <= PIXEL_BITS'(i_pixel);
            if (!col_ge_r) begin
                r_head[HIW'(r_col)] <= PIXEL_BITS'(i_pixel);
            end
            r_col_in <= r_col;
            r_ws_in  <= r_ws;
            r_rs_in  <= r_rs;
        end
    end

    // Horizontal sums, one tap per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.hsum_start) begin
            r_c    <= r_col - CW'(eff_r);
            r_cend <= col_last ? CW'(w_m1) : r_col - CW'(eff_r);
            r_k    <= '0;
            r_hacc <= '0;
        end else if (i_cmd.hsum_step) begin
            if (tap_last) begin
                r_k    <= '0;
                r_hacc <= '0;
                r_c    <= r_c + CW'(1);
            end else begin
                r_k    <= r_k + SW'(1);
                r_hacc <= hsum_next;
            end
        end
    end

    // Line memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.hsum_step && tap_last) begin
            r_mem[wr_addr] <= hsum_next;
        end
        if (i_cmd.vsum_step && issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Vertical sum over window rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_j    <= '0;
        end else if (i_cmd.vsum_start) begin
            r_pend <= 1'b0;
            r_j    <= '0;
        end else if (i_cmd.vsum_step) begin
            r_pend <= issue;
            if (issue) begin
                r_j <= r_j + JW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vsum_start) begin
            r_vacc <= '0;
        end else if (i_cmd.vsum_step && r_pend) begin
            r_vacc <= r_vacc + VW'(r_rdata);
        end
    end

    // Rounded division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem  <= NW'(r_vacc) + NW'(s2 >> 1);
            r_dsh  <= DW'(s2) << (PIXEL_BITS - 1);
            r_i    <= IW'(PIXEL_BITS - 1);
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - NW'(r_dsh);
            end
            r_dsh  <= r_dsh >> 1;
            r_i    <= r_i - IW'(1);
            r_quot <= {r_quot[PIXEL_BITS-2:0], div_ge};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean <= sbm_pkg::MEAN_W'(r_quot);
            r_fend <= fend;
        end
    end

    assign o_mean_value = r_mean;
    assign o_frame_end  = r_fend;

    always_comb begin
        o_sts.row_done    = (r_row >= eff_h);
        o_sts.emit_ok     = (r_row > FH'(eff_r)) || ((r_row == FH'(eff_r)) && col_ge_r);
        o_sts.hsum_ok     = col_ge_r;
        o_sts.tap_last    = tap_last;
        o_sts.center_last = (r_c == r_cend);
        o_sts.vsum_done   = !issue && !r_pend;
        o_sts.div_last    = (r_i == '0);
    end

endmodule

// ----- sv/sbm_ctrl.sv -----
// Controller state machine that sequences each item through the datapath.
module sbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_func,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sbm_pkg::t_sts i_sts,
    output sbm_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HSUM = 5'b00010,
        ST_VSUM = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_emit, n_emit;
    logic   r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_emit     = r_emit;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_func) begin
                        if (i_sts.row_done) begin
                            o_cmd.vsum_start = 1'b1;
                            n_state          = ST_VSUM;
                        end
                    end else if (!i_sts.row_done) begin
                        o_cmd.accept_px = 1'b1;
                        n_emit          = i_sts.emit_ok;
                        if (i_sts.hsum_ok) begin
                            o_cmd.hsum_start = 1'b1;
                            n_state          = ST_HSUM;
                        end else if (i_sts.emit_ok) begin
                            o_cmd.vsum_start = 1'b1;
                            n_state          = ST_VSUM;
                        end
                    end
                end
            end
            ST_HSUM: begin
                o_cmd.hsum_step = 1'b1;
                if (i_sts.tap_last && i_sts.center_last) begin
                    if (r_emit) begin
                        o_cmd.vsum_start = 1'b1;
                        n_state          = ST_VSUM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_VSUM: begin
                if (i_sts.vsum_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.vsum_step = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold result valid until taken
    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/sbm_checker.sv -----
// Port-level checker for the separable box mean filter, with its bind.
module sbm_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // A new result only appears after a busy cycle
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without work in progress");

    // The block is ready for the next item as soon as a result is loaded
    a_rise_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("not ready for the next item after loading a result");

endmodule

bind separable_box_mean_filter sbm_props u_sbm_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);
